// ----- design/pgsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgsb_pkg
// Shared types and constants for the gain schedule and blend block.
// ----------------------------------------------------------------------------
package pgsb_pkg;

    localparam int NUM_JOINTS_DEF = 8;
    localparam int MAX_POINTS_DEF = 8;
    localparam int NUM_BANKS_DEF  = 3;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 48;
    localparam int DIV_STEPS  = 32;
    localparam int DCNT_W     = 5;
    localparam int LANES      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_TOTAL = 2'd2;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_CAPTURE = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         gait_bank;
        logic [2:0]         joint;
        logic [2:0]         point_index;
        logic signed [15:0] position;
        logic [31:0]        gain_p;
        logic [31:0]        gain_i;
        logic [31:0]        gain_d;
        logic [3:0]         point_count;
    } t_item;

    typedef struct packed {
        logic [31:0] sched_p;
        logic [31:0] sched_i;
        logic [31:0] sched_d;
        logic [31:0] blend_p;
        logic [31:0] blend_i;
        logic [31:0] blend_d;
        logic [2:0]  found_point;
        logic        status;
    } t_result;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic chk_err;
        logic scan_init;
        logic scan_cmp;
        logic scan_last;
        logic take_gain;
        logic mul;
        logic div_step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       has_pts;
        logic       k_end;
        logic       hit;
        logic       div_last;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/pid_gain_schedule_blend_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_gain_schedule_blend_top
// Gain scheduling over breakpoint tables with linear blend from old gains.
// ----------------------------------------------------------------------------
// One item at a time; busy is high from the cycle after start until the
// result strobe. A load item writes its entry in the load state before the
// strobe, an unused-mode item strobes o_valid in the cycle after start, and a
// joint without points goes from the check state to the strobe. Capture and
// query scan the joint's breakpoints one table entry at a time through the
// single RAM port, then fetch the gains; query then runs the blend as
// three 32-step restoring dividers side by side. The receiver cannot stall:
// o_result is valid only in the cycle o_valid is high.
module pid_gain_schedule_blend_top #(
    parameter int NUM_JOINTS = pgsb_pkg::NUM_JOINTS_DEF,
    parameter int MAX_POINTS = pgsb_pkg::MAX_POINTS_DEF,
    parameter int NUM_BANKS  = pgsb_pkg::NUM_BANKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire pgsb_pkg::t_item                 i_item,
    output logic                                 o_valid,
    output pgsb_pkg::t_result                    o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [pgsb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pgsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    pgsb_pkg::t_cmd cmd;
    pgsb_pkg::t_sts sts;

    pgsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_item.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    pgsb_dp #(
        .NUM_JOINTS (NUM_JOINTS),
        .MAX_POINTS (MAX_POINTS),
        .NUM_BANKS  (NUM_BANKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after result strobe");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside an item");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status) |-> (o_result.sched_p == '0 &&
            o_result.blend_p == '0 && o_result.found_point == '0))
        else $error("error result carries nonzero fields");
endmodule
`default_nettype wire

// ----- design/pgsb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgsb_ram
// Single-port RAM, per cycle one optional write and one registered read.
// ----------------------------------------------------------------------------
module pgsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- design/pgsb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgsb_ctrl
// Sequencer: load, breakpoint scan, gain fetch, multiply and divide steps.
// ----------------------------------------------------------------------------
module pgsb_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire logic [1:0]   i_mode,
    input  wire pgsb_pkg::t_sts i_sts,
    output pgsb_pkg::t_cmd    o_cmd,
    output logic              busy,
    output logic              o_valid
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LOAD  = 11'b000_0000_0010,
        S_CHECK = 11'b000_0000_0100,
        S_RD    = 11'b000_0000_1000,
        S_CMP   = 11'b000_0001_0000,
        S_GRD   = 11'b000_0010_0000,
        S_GWAIT = 11'b000_0100_0000,
        S_MUL   = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    case (i_mode)
                        pgsb_pkg::MODE_LOAD:    n_state = S_LOAD;
                        pgsb_pkg::MODE_CAPTURE: n_state = S_CHECK;
                        pgsb_pkg::MODE_QUERY:   n_state = S_CHECK;
                        default:                n_state = S_OUT;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state = S_OUT;
            end
            S_CHECK: begin
                if (i_sts.has_pts) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.chk_err = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_RD: begin
                if (i_sts.k_end) begin
                    o_cmd.scan_last = 1'b1;
                    n_state = S_GRD;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = i_sts.hit ? S_GRD : S_RD;
            end
            S_GRD: begin
                n_state = S_GWAIT;
            end
            S_GWAIT: begin
                o_cmd.take_gain = 1'b1;
                n_state = (i_sts.mode == pgsb_pkg::MODE_QUERY) ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

// ----- design/pgsb_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgsb_dp
// Datapath: tables, point counts, old gains, scan and three blend lanes.
// ----------------------------------------------------------------------------
module pgsb_dp #(
    parameter int NUM_JOINTS = pgsb_pkg::NUM_JOINTS_DEF,
    parameter int MAX_POINTS = pgsb_pkg::MAX_POINTS_DEF,
    parameter int NUM_BANKS  = pgsb_pkg::NUM_BANKS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pgsb_pkg::t_item                     i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [pgsb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pgsb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire pgsb_pkg::t_cmd                      i_cmd,
    output pgsb_pkg::t_sts                           o_sts,
    output pgsb_pkg::t_result                        o_result
);
    localparam int SLOTS   = NUM_BANKS * NUM_JOINTS;
    localparam int ENTRIES = SLOTS * MAX_POINTS;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int JNT_W   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int PT_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int L       = pgsb_pkg::LANES;

    // latched item
    logic [1:0]         r_mode, r_bank;
    logic [2:0]         r_joint, r_pidx;
    logic signed [15:0] r_pos;
    logic [31:0]        r_gp, r_gi, r_gd;
    logic [3:0]         r_cnt;

    // configuration
    logic [1:0]  r_gait;
    logic [15:0] r_step, r_total;

    logic [CNT_W-1:0] r_counts [SLOTS];
    logic [31:0]      r_old [L][NUM_JOINTS];

    logic [CNT_W-1:0]   r_k;
    logic signed [15:0] r_prev;
    logic [PT_W-1:0]    r_sel;

    logic [31:0] r_sched [L];
    logic        r_up    [L];
    logic [15:0] r_rem   [L];
    logic [31:0] r_q     [L];
    logic        r_bypass;
    logic [pgsb_pkg::DCNT_W-1:0] r_dcnt;

    pgsb_pkg::t_result r_res;

    logic               load_ok, sched_ok;
    logic [ENT_W-1:0]   load_addr, scan_addr, sel_addr, bp_addr, gn_addr;
    logic [SLOT_W-1:0]  load_slot, sched_slot;
    logic [JNT_W-1:0]   jidx;
    logic [CNT_W-1:0]   cnt_sel, cnt_clamp;
    logic [15:0]        bp_rdata;
    logic signed [15:0] bp_s;
    logic [3*32-1:0]    gn_rdata;

    assign load_ok = (32'(r_bank) < NUM_BANKS) && (32'(r_joint) < NUM_JOINTS)
                     && (32'(r_pidx) < MAX_POINTS);
    assign sched_ok = (32'(r_gait) < NUM_BANKS) && (32'(r_joint) < NUM_JOINTS);

    assign load_slot  = SLOT_W'(32'(r_bank) * NUM_JOINTS + 32'(r_joint));
    assign sched_slot = SLOT_W'(32'(r_gait) * NUM_JOINTS + 32'(r_joint));
    assign load_addr  = ENT_W'(32'(load_slot) * MAX_POINTS + 32'(r_pidx));
    assign scan_addr  = ENT_W'(32'(sched_slot) * MAX_POINTS + 32'(r_k));
    assign sel_addr   = ENT_W'(32'(sched_slot) * MAX_POINTS + 32'(r_sel));
    assign jidx       = JNT_W'(r_joint);
    assign cnt_sel    = sched_ok ? r_counts[sched_slot] : '0;
    assign cnt_clamp  = (32'(r_cnt) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(r_cnt);

    assign bp_addr = i_cmd.load_wr ? load_addr : scan_addr;
    assign gn_addr = i_cmd.load_wr ? load_addr : sel_addr;

    pgsb_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && load_ok),
        .i_addr  (bp_addr),
        .i_wdata (r_pos),
        .o_rdata (bp_rdata)
    );

    pgsb_ram #(.WIDTH(3*32), .DEPTH(ENTRIES)) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && load_ok),
        .i_addr  (gn_addr),
        .i_wdata ({r_gd, r_gi, r_gp}),
        .o_rdata (gn_rdata)
    );

    assign bp_s = $signed(bp_rdata);

    assign o_sts.mode     = r_mode;
    assign o_sts.has_pts  = (cnt_sel != '0);
    assign o_sts.k_end    = (r_k == cnt_sel);
    assign o_sts.hit      = (r_k != '0) && (r_prev <= r_pos) && (r_pos < bp_s);
    assign o_sts.div_last = (r_dcnt == pgsb_pkg::DCNT_W'(pgsb_pkg::DIV_STEPS - 1));

    // control state: config, counts, old gains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gait  <= '0;
            r_step  <= '0;
            r_total <= 16'd1;
            for (int s = 0; s < SLOTS; s++) begin
                r_counts[s] <= '0;
            end
            for (int l = 0; l < L; l++) begin
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    r_old[l][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pgsb_pkg::CFG_ACTIVE_GAIT: r_gait  <= i_cfg_data[1:0];
                    pgsb_pkg::CFG_BLEND_STEP:  r_step  <= i_cfg_data;
                    pgsb_pkg::CFG_BLEND_TOTAL: r_total <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_wr && load_ok) begin
                r_counts[load_slot] <= cnt_clamp;
            end
            if (i_cmd.take_gain && (r_mode == pgsb_pkg::MODE_CAPTURE)) begin
                for (int l = 0; l < L; l++) begin
                    r_old[l][jidx] <= gn_rdata[32*l +: 32];
                end
            end
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_item.mode;
            r_bank  <= i_item.gait_bank;
            r_joint <= i_item.joint;
            r_pidx  <= i_item.point_index;
            r_pos   <= i_item.position;
            r_gp    <= i_item.gain_p;
            r_gi    <= i_item.gain_i;
            r_gd    <= i_item.gain_d;
            r_cnt   <= i_item.point_count;
            r_res   <= '0;
        end
        if (i_cmd.chk_err) begin
            r_res.status <= 1'b1;
        end
        if (i_cmd.scan_init) begin
            r_k   <= '0;
            r_sel <= '0;
        end
        if (i_cmd.scan_cmp) begin
            if (o_sts.hit) begin
                r_sel <= PT_W'(r_k - CNT_W'(1));
            end else begin
                r_prev <= bp_s;
                r_k    <= r_k + CNT_W'(1);
            end
        end
        if (i_cmd.scan_last) begin
            // only the last point left: it matches if at or above its breakpoint
            r_sel <= (r_prev <= r_pos) ? PT_W'(cnt_sel - CNT_W'(1)) : '0;
        end
        if (i_cmd.take_gain) begin
            for (int l = 0; l < L; l++) begin
                r_sched[l] <= gn_rdata[32*l +: 32];
            end
            r_res.sched_p     <= gn_rdata[31:0];
            r_res.sched_i     <= gn_rdata[63:32];
            r_res.sched_d     <= gn_rdata[95:64];
            r_res.found_point <= 3'(r_sel);
        end
        if (i_cmd.mul) begin
            r_bypass <= (r_total == '0) || (r_step >= r_total);
            r_dcnt   <= '0;
            for (int l = 0; l < L; l++) begin
                logic [31:0]                  diff;
                logic [pgsb_pkg::PROD_W-1:0]  prod;
                diff = (r_sched[l] >= r_old[l][jidx]) ? r_sched[l] - r_old[l][jidx]
                                                      : r_old[l][jidx] - r_sched[l];
                prod = pgsb_pkg::PROD_W'(diff) * pgsb_pkg::PROD_W'(r_step);
                r_up[l]  <= (r_sched[l] >= r_old[l][jidx]);
                r_rem[l] <= prod[47:32];
                r_q[l]   <= prod[31:0];
            end
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + pgsb_pkg::DCNT_W'(1);
            for (int l = 0; l < L; l++) begin
                logic [16:0] t;
                logic        qb;
                t  = {r_rem[l], r_q[l][31]};
                qb = (t >= {1'b0, r_total});
                r_rem[l] <= qb ? 16'(t - {1'b0, r_total}) : t[15:0];
                r_q[l]   <= {r_q[l][30:0], qb};
            end
        end
        if (i_cmd.fin) begin
            for (int l = 0; l < L; l++) begin
                logic [31:0] b;
                b = r_bypass ? r_sched[l] :
                    (r_up[l] ? r_old[l][jidx] + r_q[l] : r_old[l][jidx] - r_q[l]);
                case (l)
                    0:       r_res.blend_p <= b;
                    1:       r_res.blend_i <= b;
                    default: r_res.blend_d <= b;
                endcase
            end
        end
    end

    assign o_result = r_res;
endmodule
`default_nettype wire
